>>> sv/swr_pkg.sv
// Shared constants, types and helpers for the stream word replace block.
// Used by the interfaces, the front, the queue, the back and the top level.
// No dependencies.
package swr_pkg;

    localparam int PATTERN_MAX = 8;
    localparam int REPLACE_MAX = 8;
    localparam int BYTE_W      = 8;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int LEN_W       = 4;
    localparam int MATCH_W     = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 2'd3;

    // Configuration as seen by front and back, lengths already clamped
    typedef struct packed {
        logic [CFG_W-1:0] pattern;
        logic [LEN_W-1:0] plen;
        logic [CFG_W-1:0] repl;
        logic [LEN_W-1:0] rlen;
    } cfg_t;

    // One classified item: run = head pattern bytes, optional current byte,
    // then a tail of replacement bytes or flushed pattern bytes.
    typedef struct packed {
        logic [BYTE_W-1:0]  cur_byte;
        logic [MATCH_W-1:0] head_len;
        logic               cur_keep;
        logic               repl;
        logic [LEN_W-1:0]   tail_len;
        logic [LEN_W-1:0]   run_len;
        logic               eot;
        logic               found;
    } cmd_t;

    function automatic logic [BYTE_W-1:0] byte_at(input logic [CFG_W-1:0] w,
                                                  input logic [MATCH_W-1:0] i);
        byte_at = w[{i, 3'b000} +: BYTE_W];
    endfunction

endpackage

>>> sv/swr_if.sv
// Valid/ready channel interfaces for the input text and the result stream.
// Depends on swr_pkg for the byte width.
interface swr_in_if;
    logic                       valid;
    logic                       ready;
    logic [swr_pkg::BYTE_W-1:0] in_byte;
    logic                       end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface swr_out_if;
    logic                       valid;
    logic                       ready;
    logic [swr_pkg::BYTE_W-1:0] out_byte;
    logic                       has_byte;
    logic                       last_in_run;
    logic                       text_done;
    logic                       found_any;

    modport source (output valid, output out_byte, output has_byte, output last_in_run,
                    output text_done, output found_any, input ready);
    modport sink   (input valid, input out_byte, input has_byte, input last_in_run,
                    input text_done, input found_any, output ready);
endinterface

>>> sv/swr_front.sv
// Front end: accepts text bytes, tracks the matched prefix length and
// classifies each item into a run command. Depends on swr_pkg, swr_in_if.
module swr_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    swr_in_if.sink                     text_in,
    input  swr_pkg::cfg_t              cfg,
    input  logic                       cfg_clear,
    input  logic                       q_full,
    output logic                       push,
    output swr_pkg::cmd_t              cmd
);

    logic [swr_pkg::MATCH_W-1:0] m_reg;
    logic [swr_pkg::MATCH_W-1:0] m_next;
    logic                        rep_reg;
    logic                        rep_next;

    logic [swr_pkg::PATTERN_MAX-1:0][swr_pkg::PATTERN_MAX-1:0] bord;
    logic [swr_pkg::MATCH_W-1:0] plen_m1;
    logic [swr_pkg::MATCH_W-1:0] m_eff;
    logic [swr_pkg::LEN_W-1:0]   k;
    logic                        full_match;
    logic                        accept;
    logic                        eot;
    logic [swr_pkg::BYTE_W-1:0]  c;

    assign c   = text_in.in_byte;
    assign eot = text_in.end_of_text;

    // Border table: held prefix of length mm keeps a tail of length kk-1
    // that equals the pattern's own prefix
    always_comb
    begin
        logic ok;
        ok   = 1'b0;
        bord = '0;
        for (int mm = 0; mm < swr_pkg::PATTERN_MAX; mm++)
        begin
            for (int kk = 1; kk <= swr_pkg::PATTERN_MAX; kk++)
            begin
                if (kk <= mm + 1)
                begin
                    ok = 1'b1;
                    for (int i = 0; i < swr_pkg::PATTERN_MAX - 1; i++)
                    begin
                        if (i < kk - 1)
                        begin
                            ok = ok &&
                                 (swr_pkg::byte_at(cfg.pattern,
                                      swr_pkg::MATCH_W'(mm + 1 - kk + i)) ==
                                  swr_pkg::byte_at(cfg.pattern, swr_pkg::MATCH_W'(i)));
                        end
                    end
                    bord[mm][kk-1] = ok;
                end
            end
        end
    end

    // Pick the longest tail that is still a pattern prefix
    assign plen_m1 = swr_pkg::MATCH_W'(cfg.plen - 4'd1);
    assign m_eff   = (m_reg > plen_m1) ? plen_m1 : m_reg;

    always_comb
    begin
        k = '0;
        for (int kk = 1; kk <= swr_pkg::PATTERN_MAX; kk++)
        begin
            if (bord[m_eff][kk-1] && (swr_pkg::LEN_W'(kk) <= cfg.plen) &&
                (c == swr_pkg::byte_at(cfg.pattern, swr_pkg::MATCH_W'(kk - 1))))
            begin
                k = swr_pkg::LEN_W'(kk);
            end
        end
    end

    assign full_match = (k == cfg.plen);

    // Build the run command and the next match state
    always_comb
    begin
        cmd          = '0;
        cmd.cur_byte = c;
        cmd.eot      = eot;
        cmd.found    = rep_reg | full_match;
        m_next       = '0;
        if (full_match)
        begin
            cmd.repl     = 1'b1;
            cmd.tail_len = cfg.rlen;
        end
        else if (k == '0)
        begin
            cmd.head_len = m_eff;
            cmd.cur_keep = 1'b1;
        end
        else
        begin
            cmd.head_len = swr_pkg::MATCH_W'({1'b0, m_eff} + 4'd1 - k);
            cmd.tail_len = eot ? k : '0;
            m_next       = swr_pkg::MATCH_W'(k);
        end
        if (eot)
        begin
            m_next = '0;
        end
        cmd.run_len = {1'b0, cmd.head_len} + {3'b000, cmd.cur_keep} + cmd.tail_len;
    end

    assign rep_next      = eot ? 1'b0 : (rep_reg | full_match);
    assign text_in.ready = !q_full;
    assign accept        = text_in.valid && text_in.ready;
    assign push          = accept && ((cmd.run_len != '0) || eot);

    // Advance match state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_reg   <= '0;
            rep_reg <= 1'b0;
        end
        else
        begin
            if (cfg_clear)
            begin
                m_reg <= '0;
            end
            else if (accept)
            begin
                m_reg   <= m_next;
                rep_reg <= rep_next;
            end
        end
    end

    a_match_below_plen: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, m_reg} < cfg.plen)
        else $error("held prefix not shorter than pattern");

    a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && eot |=> (m_reg == '0) && !rep_reg)
        else $error("match state survives end of text");

endmodule

>>> sv/swr_queue.sv
// Four-entry command queue between front and back.
// Depends on swr_pkg.
module swr_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  swr_pkg::cmd_t cmd_in,
    output logic          full,
    input  logic          pop,
    output swr_pkg::cmd_t cmd_out,
    output logic          empty
);

    swr_pkg::cmd_t                mem_reg [swr_pkg::QUEUE_DEPTH];
    logic [swr_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [swr_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [swr_pkg::QCNT_W-1:0]   count_reg;
    logic [swr_pkg::QCNT_W-1:0]   count_next;

    assign full    = (count_reg == swr_pkg::QCNT_W'(swr_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign cmd_out = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= swr_pkg::QCNT_W'(swr_pkg::QUEUE_DEPTH))
        else $error("queue count overflow");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

endmodule

>>> sv/swr_back.sv
// Back end: expands each queued run command into result items, one per
// cycle while the result stream is not stalled, through a registered output stage. Depends on swr_pkg, swr_out_if.
module swr_back
(
    input  logic          clk,
    input  logic          rst_n,
    swr_out_if.source     text_out,
    input  swr_pkg::cfg_t cfg,
    input  swr_pkg::cmd_t cmd,
    input  logic          q_empty,
    output logic          pop
);

    logic [swr_pkg::LEN_W-1:0]   j_reg;
    logic [swr_pkg::LEN_W-1:0]   j_next;
    logic                        out_valid_reg;
    logic [swr_pkg::BYTE_W-1:0]  out_byte_reg;
    logic                        has_byte_reg;
    logic                        last_reg;
    logic                        done_reg;
    logic                        found_reg;

    logic [swr_pkg::LEN_W-1:0]   run_eff;
    logic                        last;
    logic                        load;
    logic [swr_pkg::BYTE_W-1:0]  sel_byte;
    logic [swr_pkg::MATCH_W-1:0] t;

    assign run_eff = (cmd.run_len == '0) ? 4'd1 : cmd.run_len;
    assign last    = (j_reg == run_eff - 4'd1);
    assign load    = !out_valid_reg || text_out.ready;
    assign pop     = load && !q_empty && last;
    assign j_next  = last ? '0 : j_reg + 4'd1;
    assign t       = swr_pkg::MATCH_W'(j_reg - {1'b0, cmd.head_len} - {3'b000, cmd.cur_keep});

    // Select the byte at run position j
    always_comb
    begin
        if (cmd.run_len == '0)
        begin
            sel_byte = '0;
        end
        else if (j_reg < {1'b0, cmd.head_len})
        begin
            sel_byte = swr_pkg::byte_at(cfg.pattern, j_reg[swr_pkg::MATCH_W-1:0]);
        end
        else if (cmd.cur_keep && (j_reg == {1'b0, cmd.head_len}))
        begin
            sel_byte = cmd.cur_byte;
        end
        else if (cmd.repl)
        begin
            sel_byte = swr_pkg::byte_at(cfg.repl, t);
        end
        else
        begin
            sel_byte = swr_pkg::byte_at(cfg.pattern, t);
        end
    end

    // Hold or advance the output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            j_reg         <= '0;
        end
        else if (load)
        begin
            out_valid_reg <= !q_empty;
            if (!q_empty)
            begin
                j_reg <= j_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && !q_empty)
        begin
            out_byte_reg <= sel_byte;
            has_byte_reg <= (cmd.run_len != '0);
            last_reg     <= last;
            done_reg     <= last && cmd.eot;
            found_reg    <= last && cmd.eot && cmd.found;
        end
    end

    assign text_out.valid       = out_valid_reg;
    assign text_out.out_byte    = out_byte_reg;
    assign text_out.has_byte    = has_byte_reg;
    assign text_out.last_in_run = last_reg;
    assign text_out.text_done   = done_reg;
    assign text_out.found_any   = found_reg;

    a_pos_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        !q_empty |-> (j_reg < run_eff))
        else $error("run position past run length");

endmodule

>>> sv/stream_word_replace.sv
// Top level of the stream word replace block: configuration registers,
// front end, command queue and back end. Depends on swr_pkg and swr_if.
// An accepted item is written into the queue and its first result then goes
// to the output register. Throughput: one item per cycle while runs are one
// result long and the output is not stalled; longer runs hold the back end,
// and the four-entry queue absorbs bursts and stalls input only when it fills.
// Reset: registers take their reset values, match state and queue clear.
module stream_word_replace
(
    input  logic                          clk,
    input  logic                          rst_n,
    swr_in_if.sink                        text_in,
    swr_out_if.source                     text_out,
    input  logic                          cfg_we,
    input  logic [swr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [swr_pkg::CFG_W-1:0]     cfg_data
);

    logic [swr_pkg::CFG_W-1:0] pattern_reg;
    logic [swr_pkg::LEN_W-1:0] plen_reg;
    logic [swr_pkg::CFG_W-1:0] repl_reg;
    logic [swr_pkg::LEN_W-1:0] rlen_reg;

    swr_pkg::cfg_t cfg;
    swr_pkg::cmd_t push_cmd;
    swr_pkg::cmd_t head_cmd;
    logic          cfg_clear;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            plen_reg    <= 4'd1;
            repl_reg    <= '0;
            rlen_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                swr_pkg::REG_PATTERN_BYTES:      pattern_reg <= cfg_data;
                swr_pkg::REG_PATTERN_LENGTH:     plen_reg    <= cfg_data[swr_pkg::LEN_W-1:0];
                swr_pkg::REG_REPLACEMENT_BYTES:  repl_reg    <= cfg_data;
                swr_pkg::REG_REPLACEMENT_LENGTH: rlen_reg    <= cfg_data[swr_pkg::LEN_W-1:0];
                default:                         pattern_reg <= pattern_reg;
            endcase
        end
    end

    // Clamp lengths into range
    always_comb
    begin
        cfg.pattern = pattern_reg;
        cfg.repl    = repl_reg;
        if (plen_reg == '0)
        begin
            cfg.plen = 4'd1;
        end
        else if (plen_reg > swr_pkg::LEN_W'(swr_pkg::PATTERN_MAX))
        begin
            cfg.plen = swr_pkg::LEN_W'(swr_pkg::PATTERN_MAX);
        end
        else
        begin
            cfg.plen = plen_reg;
        end
        if (rlen_reg > swr_pkg::LEN_W'(swr_pkg::REPLACE_MAX))
        begin
            cfg.rlen = swr_pkg::LEN_W'(swr_pkg::REPLACE_MAX);
        end
        else
        begin
            cfg.rlen = rlen_reg;
        end
    end

    // Drop the held prefix when the pattern changes
    assign cfg_clear = cfg_we && ((cfg_index == swr_pkg::REG_PATTERN_BYTES) ||
                                  (cfg_index == swr_pkg::REG_PATTERN_LENGTH));

    swr_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_in   (text_in),
        .cfg       (cfg),
        .cfg_clear (cfg_clear),
        .q_full    (q_full),
        .push      (push),
        .cmd       (push_cmd)
    );

    swr_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .cmd_in  (push_cmd),
        .full    (q_full),
        .pop     (pop),
        .cmd_out (head_cmd),
        .empty   (q_empty)
    );

    swr_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .text_out (text_out),
        .cfg      (cfg),
        .cmd      (head_cmd),
        .q_empty  (q_empty),
        .pop      (pop)
    );

endmodule

>>> test/tb_stream_word_replace.sv
// Testbench for stream_word_replace: directed and random texts are checked
// result by result against a find-and-replace predictor with KMP fallback.
// Depends on swr_pkg, the swr_in_if/swr_out_if interfaces and the block RTL.
module tb_stream_word_replace;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_ITEMS  = 56;

    typedef struct packed {
        logic [swr_pkg::BYTE_W-1:0] out_byte;
        logic                       has_byte;
        logic                       last_in_run;
        logic                       text_done;
        logic                       found_any;
    } rewrite_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_we;
    logic [swr_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [swr_pkg::CFG_W-1:0]     cfg_data;

    swr_in_if  text_in_ch ();
    swr_out_if text_out_ch ();

    stream_word_replace dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_in   (text_in_ch),
        .text_out  (text_out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor copy of the registers and the match state
    logic [swr_pkg::CFG_W-1:0]   model_pattern;
    logic [swr_pkg::LEN_W-1:0]   model_plen;
    logic [swr_pkg::CFG_W-1:0]   model_repl;
    logic [swr_pkg::LEN_W-1:0]   model_rlen;
    logic [swr_pkg::MATCH_W-1:0] held_len;
    logic                        found_flag;

    rewrite_result_t pending_rewrite [$];

    bit src_idle_on;
    bit sink_stall_on;
    int items_sent;
    int texts_sent;
    int results_checked;
    int mismatch_count;
    int cycle_count;

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic int pattern_span();
        if (model_plen == 0)
            return 1;
        if (model_plen > swr_pkg::PATTERN_MAX)
            return swr_pkg::PATTERN_MAX;
        return int'(model_plen);
    endfunction

    function automatic logic [swr_pkg::BYTE_W-1:0] pattern_byte(input int i);
        return model_pattern[swr_pkg::BYTE_W*i +: swr_pkg::BYTE_W];
    endfunction

    function automatic rewrite_result_t text_byte_result(input logic [swr_pkg::BYTE_W-1:0] b);
        return {b, 1'b1, 3'b000};
    endfunction

    // Work out the results of one accepted text item and queue them
    task automatic predict_rewrite(input logic [swr_pkg::BYTE_W-1:0] c, input logic eot);
        logic [swr_pkg::BYTE_W-1:0] held [0:swr_pkg::PATTERN_MAX-1];
        rewrite_result_t            run [$];
        rewrite_result_t            last;
        int                         plen;
        int                         rlen;
        int                         m;
        int                         slen;
        int                         k;
        int                         i;
        bit                         ok;
        plen = pattern_span();
        rlen = (model_rlen > swr_pkg::REPLACE_MAX) ? swr_pkg::REPLACE_MAX : int'(model_rlen);
        m = int'(held_len);
        if (m > plen - 1)
            m = plen - 1;
        for (i = 0; i < m; i++)
            held[i] = pattern_byte(i);
        held[m] = c;
        slen = m + 1;

        // find the longest tail of the held bytes that still starts the pattern
        for (k = (slen < plen) ? slen : plen; k > 0; k--)
        begin
            ok = 1'b1;
            for (i = 0; i < k; i++)
                if (held[slen - k + i] != pattern_byte(i))
                    ok = 1'b0;
            if (ok)
                break;
        end

        // release bytes that can no longer start a match
        for (i = 0; i + k < slen; i++)
            run.push_back(text_byte_result(held[i]));

        if (k == plen)
        begin
            for (i = 0; i < rlen; i++)
                run.push_back(text_byte_result(
                    model_repl[swr_pkg::BYTE_W*i +: swr_pkg::BYTE_W]));
            found_flag = 1'b1;
            m = 0;
        end
        else
        begin
            m = k;
        end

        // flush the held prefix and close the text
        if (eot)
        begin
            for (i = 0; i < m; i++)
                run.push_back(text_byte_result(pattern_byte(i)));
            if (run.size() == 0)
                run.push_back('0);
            last = run.pop_back();
            last.text_done = 1'b1;
            last.found_any = found_flag;
            run.push_back(last);
            m = 0;
            found_flag = 1'b0;
        end

        if (run.size() > 0)
        begin
            last = run.pop_back();
            last.last_in_run = 1'b1;
            run.push_back(last);
        end
        held_len = m[swr_pkg::MATCH_W-1:0];
        for (i = 0; i < run.size(); i++)
            pending_rewrite.push_back(run[i]);
    endtask

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Send one text item; valid stays high afterwards for back-to-back items
    task automatic send_text_byte(input logic [swr_pkg::BYTE_W-1:0] b, input logic eot);
        if (src_idle_on && $urandom_range(99) < 20)
        begin
            text_in_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 40);
        end
        text_in_ch.valid       <= 1'b1;
        text_in_ch.in_byte     <= b;
        text_in_ch.end_of_text <= eot;
        // sample ready away from the active edge
        do
            @(negedge clk);
        while (!text_in_ch.ready);
        @(posedge clk);
        predict_rewrite(b, eot);
        items_sent++;
        if (eot)
            texts_sent++;
    endtask

    // Drop valid and hold until every expected result has come out
    task automatic drain_results();
        text_in_ch.valid <= 1'b0;
        while (pending_rewrite.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write one register while the block is idle, then drop the enable and wait
    task automatic write_register(input logic [swr_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [swr_pkg::CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            swr_pkg::REG_PATTERN_BYTES:
            begin
                model_pattern = value;
                held_len = '0;
            end
            swr_pkg::REG_PATTERN_LENGTH:
            begin
                model_plen = value[swr_pkg::LEN_W-1:0];
                held_len = '0;
            end
            swr_pkg::REG_REPLACEMENT_BYTES:  model_repl = value;
            swr_pkg::REG_REPLACEMENT_LENGTH: model_rlen = value[swr_pkg::LEN_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Build one text from pattern pieces, stray pattern bytes and noise
    task automatic send_random_text();
        logic [swr_pkg::BYTE_W-1:0] text [$];
        int                         text_len;
        int                         span;
        int                         n;
        int                         i;
        int                         pick;
        text_len = $urandom_range(24, 1);
        span = pattern_span();
        while (text.size() < text_len)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                // whole pattern, or a prefix that the next piece may break
                n = ($urandom_range(1) != 0) ? span : $urandom_range(span, 1);
                for (i = 0; i < n; i++)
                    text.push_back(pattern_byte(i));
            end
            else if (pick < 80)
            begin
                text.push_back(pattern_byte($urandom_range(span - 1)));
            end
            else
            begin
                text.push_back(swr_pkg::BYTE_W'($urandom_range(255)));
            end
        end
        for (i = 0; i < text.size(); i++)
            send_text_byte(text[i], i == text.size() - 1);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings: single zero byte pattern, empty replacement
    task automatic test_reset_settings();
        send_text_byte(8'h41, 1'b0);
        send_text_byte(8'h00, 1'b0);
        send_text_byte(8'hFF, 1'b1);
        // a text that is only a match leaves a bare end marker
        send_text_byte(8'h00, 1'b1);
    endtask

    // Self-overlapping pattern: a mismatch must keep the useful tail
    task automatic test_kmp_fallback();
        drain_results();
        write_register(swr_pkg::REG_PATTERN_BYTES, 64'h0000_0000_0062_6161);
        write_register(swr_pkg::REG_PATTERN_LENGTH, 64'd3);
        write_register(swr_pkg::REG_REPLACEMENT_BYTES, 64'h0000_0000_0000_5958);
        write_register(swr_pkg::REG_REPLACEMENT_LENGTH, 64'd2);
        send_text_byte(8'h61, 1'b0);
        send_text_byte(8'h61, 1'b0);
        send_text_byte(8'h61, 1'b0);
        send_text_byte(8'h62, 1'b1);
        // held prefix broken by the last byte, nothing found
        send_text_byte(8'h61, 1'b0);
        send_text_byte(8'h62, 1'b1);
    endtask

    // Length registers above the maximum and a zero pattern length
    task automatic test_length_clamps();
        int i;
        drain_results();
        write_register(swr_pkg::REG_PATTERN_BYTES, '1);
        write_register(swr_pkg::REG_PATTERN_LENGTH, 64'd15);
        write_register(swr_pkg::REG_REPLACEMENT_BYTES, 64'h0123_4567_89AB_CDEF);
        write_register(swr_pkg::REG_REPLACEMENT_LENGTH, 64'd15);
        for (i = 0; i < swr_pkg::PATTERN_MAX; i++)
            send_text_byte(8'hFF, i == swr_pkg::PATTERN_MAX - 1);
        drain_results();
        write_register(swr_pkg::REG_PATTERN_LENGTH, 64'd0);
        write_register(swr_pkg::REG_REPLACEMENT_LENGTH, 64'd8);
        send_text_byte(8'hFF, 1'b0);
        send_text_byte(8'h7E, 1'b1);
    endtask

    // Pattern write in the middle of a text drops the held prefix
    task automatic test_pattern_rewrite();
        drain_results();
        write_register(swr_pkg::REG_PATTERN_BYTES, 64'h0000_0000_0063_6261);
        write_register(swr_pkg::REG_PATTERN_LENGTH, 64'd3);
        send_text_byte(8'h61, 1'b0);
        send_text_byte(8'h62, 1'b0);
        drain_results();
        write_register(swr_pkg::REG_PATTERN_BYTES, 64'h0000_0000_007A_7978);
        send_text_byte(8'h63, 1'b1);
    endtask

    // Random settings, each followed by a run of random texts
    task automatic test_random_texts();
        logic [swr_pkg::BYTE_W-1:0] a_byte;
        logic [swr_pkg::BYTE_W-1:0] b_byte;
        logic [swr_pkg::CFG_W-1:0]  pat;
        int                         phase;
        int                         quota;
        int                         i;
        for (phase = 0; phase < 6; phase++)
        begin
            drain_results();
            // one quiet phase with no gaps and no stalls at all
            src_idle_on   = (phase != 2);
            sink_stall_on = (phase != 2);
            if ($urandom_range(1) != 0)
            begin
                // two-letter pattern, rich in self-overlap
                a_byte = swr_pkg::BYTE_W'($urandom_range(255));
                b_byte = swr_pkg::BYTE_W'($urandom_range(255));
                for (i = 0; i < swr_pkg::PATTERN_MAX; i++)
                    pat[swr_pkg::BYTE_W*i +: swr_pkg::BYTE_W] =
                        ($urandom_range(1) != 0) ? a_byte : b_byte;
            end
            else
            begin
                pat = {$urandom, $urandom};
            end
            write_register(swr_pkg::REG_PATTERN_BYTES, pat);
            write_register(swr_pkg::REG_PATTERN_LENGTH, ($urandom_range(9) == 0) ?
                           64'($urandom_range(15)) : 64'($urandom_range(8, 1)));
            write_register(swr_pkg::REG_REPLACEMENT_BYTES, {$urandom, $urandom});
            write_register(swr_pkg::REG_REPLACEMENT_LENGTH, ($urandom_range(9) == 0) ?
                           64'($urandom_range(15, 9)) : 64'($urandom_range(8)));
            quota = items_sent + PHASE_ITEMS;
            while (items_sent < quota)
                send_random_text();
        end
        src_idle_on   = 1'b1;
        sink_stall_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Stall the result stream at random
    initial
    begin
        text_out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            text_out_ch.ready <= !sink_stall_on || ($urandom_range(99) >= 20);
        end
    end

    function automatic void check_field(input string field_name,
                                        input logic [swr_pkg::BYTE_W-1:0] want,
                                        input logic [swr_pkg::BYTE_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", field_name, want, got);
            mismatch_count++;
        end
    endfunction

    // Compare each result taken at the next edge with the oldest expectation
    always @(negedge clk)
    begin : check_results
        rewrite_result_t want;
        if (rst_n && text_out_ch.valid && text_out_ch.ready)
        begin
            if (pending_rewrite.size() == 0)
            begin
                $error("result with no item waiting: out_byte %0h", text_out_ch.out_byte);
                mismatch_count++;
            end
            else
            begin
                want = pending_rewrite.pop_front();
                check_field("out_byte", want.out_byte, text_out_ch.out_byte);
                check_field("has_byte", want.has_byte, text_out_ch.has_byte);
                check_field("last_in_run", want.last_in_run, text_out_ch.last_in_run);
                check_field("text_done", want.text_done, text_out_ch.text_done);
                check_field("found_any", want.found_any, text_out_ch.found_any);
                results_checked++;
            end
        end
    end

    // Bound the run
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n                  <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_index              <= swr_pkg::REG_PATTERN_BYTES;
        cfg_data               <= '0;
        text_in_ch.valid       <= 1'b0;
        text_in_ch.in_byte     <= '0;
        text_in_ch.end_of_text <= 1'b0;
        model_pattern   = '0;
        model_plen      = swr_pkg::LEN_W'(1);
        model_repl      = '0;
        model_rlen      = '0;
        held_len        = '0;
        found_flag      = 1'b0;
        src_idle_on     = 1'b1;
        sink_stall_on   = 1'b1;
        items_sent      = 0;
        texts_sent      = 0;
        results_checked = 0;
        mismatch_count  = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_settings();
        test_kmp_fallback();
        test_length_clamps();
        test_pattern_rewrite();
        test_random_texts();
        drain_results();

        $display("Ran %0d items in %0d texts and checked %0d results.",
                 items_sent, texts_sent, results_checked);
        $display("Covered reset settings, end markers, overlap fallback, length clamps,"
                 , " mid-text pattern writes and six random settings.");
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
